### rtl/slui_pkg.sv
// Shared constants for the sorted list insert / union core.
// Widths, list depth, request opcodes and result kinds. No dependencies.
`default_nettype none

package slui_pkg;

   localparam int DEPTH  = 32;
   localparam int WORD_W = 32;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int OP_W   = 2;
   localparam int KIND_W = 2;

   localparam logic [CNT_W-1:0] LIST_FULL = CNT_W'(DEPTH);

   // request opcodes
   localparam logic [OP_W-1:0] OP_INSERT_A = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT_B = 2'd1;
   localparam logic [OP_W-1:0] OP_MERGE    = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP      = 2'd3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VALUE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

endpackage

`default_nettype wire

### rtl/slui_req_if.sv
// Request channel: valid/ready handshake with opcode and value.
// Depends on slui_pkg for field widths.
`default_nettype none

interface slui_req_if import slui_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          opcode;
   logic signed [WORD_W-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

### rtl/slui_rsp_if.sv
// Result channel: valid/ready handshake with kind, value, drop and last flags.
// Depends on slui_pkg for field widths.
`default_nettype none

interface slui_rsp_if import slui_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [WORD_W-1:0] value_out;
   logic                     dropped;
   logic                     last;

   modport source (output valid, output kind, output value_out, output dropped,
                   output last, input ready);
   modport sink   (input valid, input kind, input value_out, input dropped,
                   input last, output ready);
endinterface

`default_nettype wire

### rtl/sorted_list_insert_union_core.sv
// Top level of the sorted list insert / union core: sequencer, two list RAMs
// and the shared comparator. Depends on slui_pkg, slui_req_if, slui_rsp_if,
// slui_ram and slui_cmp.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+----------------------------------
//   req_ch    | in        | valid / ready      | opcode[1:0], value[31:0] signed
//   rsp_ch    | out       | valid / ready      | kind[1:0], value_out[31:0] signed,
//             |           |                    | dropped, last
//
// An insert steps down past each entry greater than the value, shifting it up,
// then writes the value and reports status; a dropped insert reports straight
// away; a merge walks every entry of both lists, then emits the last value or
// an empty result. The walk is bound by the single read port of each list RAM
// and the one comparator, which both an insert scan and a merge step use.
// Reset: synchronous, clears the counts, sequencer and output valid; list
// contents are left as they are, only entries below a count are ever used.
// Stalls: the result register frees the input side; a merge that finds a new
// distinct value while holding one, with the result register full, holds its pointers.
`default_nettype none

module sorted_list_insert_union_core import slui_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   slui_req_if.sink   req_ch,
   slui_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_STATUS,
      ST_MERGE,
      ST_FINISH
   } state_type;

   // sequencer and list state
   state_type                state_ff, state_in;
   logic                     sel_b_ff, sel_b_in;
   logic signed [WORD_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0]         cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0]         ia_ff, ia_in;
   logic [CNT_W-1:0]         ib_ff, ib_in;
   logic                     have_ff, have_in;
   logic signed [WORD_W-1:0] prev_ff, prev_in;
   logic                     dropped_ff, dropped_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]        rsp_kind_ff, rsp_kind_in;
   logic signed [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_dropped_ff, rsp_dropped_in;
   logic                     rsp_last_ff, rsp_last_in;

   // datapath
   logic signed [WORD_W-1:0] a_rd, b_rd, cur_data, next_val;
   logic signed [WORD_W-1:0] cmp_lhs, cmp_rhs, wr_data;
   logic                     le, out_free, a_ok, b_ok, take_a, distinct, shift;
   logic                     wr_en;
   logic [CNT_W-1:0]         req_cnt, rem_m1;
   logic [ADDR_W-1:0]        ins_addr, wr_addr, rd_addr_a, rd_addr_b;
   logic                     ins_next;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign cur_data = sel_b_ff ? b_rd : a_rd;

   // comparator: merge orders the two heads, insert tests the scanned entry
   assign cmp_lhs = (state_ff == ST_MERGE) ? a_rd : cur_data;
   assign cmp_rhs = (state_ff == ST_MERGE) ? b_rd : val_ff;

   slui_cmp u_cmp (
      .lhs (cmp_lhs),
      .rhs (cmp_rhs),
      .le  (le)
   );

   assign a_ok     = ia_ff < cnt_a_ff;
   assign b_ok     = ib_ff < cnt_b_ff;
   assign take_a   = !b_ok || (a_ok && le);
   assign next_val = take_a ? a_rd : b_rd;
   assign distinct = !have_ff || (next_val != prev_ff);

   // insert scans downwards: shift the entry up while it is greater than the value
   assign shift   = (rem_ff != '0) && !le;
   assign wr_data = shift ? cur_data : val_ff;
   assign wr_addr = rem_ff[ADDR_W-1:0];

   assign req_cnt = (req_ch.opcode == OP_INSERT_B) ? cnt_b_ff : cnt_a_ff;

   always_comb begin
      state_in       = state_ff;
      sel_b_in       = sel_b_ff;
      val_in         = val_ff;
      rem_in         = rem_ff;
      cnt_a_in       = cnt_a_ff;
      cnt_b_in       = cnt_b_ff;
      ia_in          = ia_ff;
      ib_in          = ib_ff;
      have_in        = have_ff;
      prev_in        = prev_ff;
      dropped_in     = dropped_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               sel_b_in = (req_ch.opcode == OP_INSERT_B);
               val_in   = req_ch.value;
               ia_in    = '0;
               ib_in    = '0;
               have_in  = 1'b0;
               unique case (req_ch.opcode)
                  OP_INSERT_A, OP_INSERT_B: begin
                     if (req_cnt == LIST_FULL) begin
                        // list full: drop the value, report straight away
                        dropped_in = 1'b1;
                        state_in   = ST_STATUS;
                     end else begin
                        dropped_in = 1'b0;
                        rem_in     = req_cnt;
                        state_in   = ST_INSERT;
                     end
                  end
                  OP_MERGE: begin
                     state_in = ST_MERGE;
                  end
                  default: begin
                     // unused opcode: accept and ignore
                  end
               endcase
            end
         end

         ST_INSERT: begin
            wr_en = 1'b1;
            if (shift) begin
               rem_in = rem_ff - CNT_W'(1);
            end else begin
               state_in = ST_STATUS;
               if (sel_b_ff) begin
                  cnt_b_in = cnt_b_ff + CNT_W'(1);
               end else begin
                  cnt_a_in = cnt_a_ff + CNT_W'(1);
               end
            end
         end

         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_STATUS;
               rsp_value_in   = '0;
               rsp_dropped_in = dropped_ff;
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         ST_MERGE: begin
            if (!a_ok && !b_ok) begin
               state_in = ST_FINISH;
            end else if (!(distinct && have_ff && !out_free)) begin
               if (take_a) begin
                  ia_in = ia_ff + CNT_W'(1);
               end else begin
                  ib_in = ib_ff + CNT_W'(1);
               end
               if (distinct) begin
                  // a new value retires the held one, which is not the last
                  if (have_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_kind_in    = KIND_VALUE;
                     rsp_value_in   = prev_ff;
                     rsp_dropped_in = 1'b0;
                     rsp_last_in    = 1'b0;
                  end
                  prev_in = next_val;
                  have_in = 1'b1;
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = have_ff ? KIND_VALUE : KIND_EMPTY;
               rsp_value_in   = have_ff ? prev_ff : '0;
               rsp_dropped_in = 1'b0;
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // read addresses follow the next pointer values, so registered read data lines up with the registered pointers
   assign ins_next  = (state_in == ST_INSERT);
   assign rem_m1    = rem_in - CNT_W'(1);
   assign ins_addr  = rem_m1[ADDR_W-1:0];
   assign rd_addr_a = (ins_next && !sel_b_in) ? ins_addr : ia_in[ADDR_W-1:0];
   assign rd_addr_b = (ins_next && sel_b_in) ? ins_addr : ib_in[ADDR_W-1:0];

   slui_ram #(
      .RAM_WIDTH (WORD_W),
      .RAM_DEPTH (DEPTH)
   ) u_list_a (
      .clock   (clock),
      .wr_en   (wr_en && !sel_b_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_a),
      .rd_data (a_rd)
   );

   slui_ram #(
      .RAM_WIDTH (WORD_W),
      .RAM_DEPTH (DEPTH)
   ) u_list_b (
      .clock   (clock),
      .wr_en   (wr_en && sel_b_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_b),
      .rd_data (b_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_b_ff       <= sel_b_in;
      val_ff         <= val_in;
      rem_ff         <= rem_in;
      ia_ff          <= ia_in;
      ib_ff          <= ib_in;
      prev_ff        <= prev_in;
      dropped_ff     <= dropped_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.kind      = rsp_kind_ff;
   assign rsp_ch.value_out = rsp_value_ff;
   assign rsp_ch.dropped   = rsp_dropped_ff;
   assign rsp_ch.last      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= LIST_FULL) && (cnt_b_ff <= LIST_FULL))
      else $error("list count beyond depth");

   a_insert_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> (rem_ff < LIST_FULL) &&
         (rem_ff <= (sel_b_ff ? cnt_b_ff : cnt_a_ff)))
      else $error("insert scan outside the list");

   a_merge_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (ia_ff <= cnt_a_ff) && (ib_ff <= cnt_b_ff))
      else $error("merge pointer past list end");

   a_merge_keeps_lists: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |=> (cnt_a_ff == $past(cnt_a_ff)) &&
         (cnt_b_ff == $past(cnt_b_ff)))
      else $error("merge changed a list count");
`endif

endmodule

`default_nettype wire

### rtl/slui_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module slui_ram #(
   parameter int RAM_WIDTH = 32,
   parameter int RAM_DEPTH = 32
) (
   input  wire logic                                              clock,
   input  wire logic                                              wr_en,
   input  wire logic [((RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [RAM_WIDTH-1:0]                              wr_data,
   input  wire logic [((RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1)-1:0] rd_addr,
   output      logic [RAM_WIDTH-1:0]                              rd_data
);
   logic [RAM_WIDTH-1:0] mem [RAM_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

`default_nettype wire

### rtl/slui_cmp.sv
// Shared signed comparator: lhs <= rhs via a widened subtract.
// Depends on slui_pkg for the word width.
`default_nettype none

module slui_cmp import slui_pkg::*; (
   input  wire logic signed [WORD_W-1:0] lhs,
   input  wire logic signed [WORD_W-1:0] rhs,
   output      logic                     le
);
   logic [WORD_W:0] diff;

   // sign-extend by one bit so the borrow never overflows
   assign diff = {lhs[WORD_W-1], lhs} - {rhs[WORD_W-1], rhs};
   assign le   = diff[WORD_W] || (diff == '0);
endmodule

`default_nettype wire
